/* src/homogeneous_matrix_inverse_macros.svh */
`ifndef HOMOGENEOUS_MATRIX_INVERSE_MACROS_SVH
`define HOMOGENEOUS_MATRIX_INVERSE_MACROS_SVH

// clocked check, off during reset
`define HMI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked implication, off during reset
`define HMI_ASSERT_IMP(label, ante, cons, msg) \
   `HMI_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* src/hmi_pkg.sv */
`timescale 1ns / 1ps

package hmi_pkg;

   localparam int DATA_W     = 32;
   localparam int ACC_W      = 100;
   localparam int N_ENTRY    = 12;
   localparam int N_UOP      = 30;
   localparam int IDX_W      = 4;
   localparam int STEP_W     = 5;
   localparam int DET_W      = 64;
   localparam int RSP_DATA_W = 104;

   typedef struct packed {
      logic [IDX_W-1:0] x_idx;
      logic [IDX_W-1:0] y_idx;
      logic             y_num;
      logic             sub;
      logic             clr;
      logic             wr;
      logic             wr_det;
      logic [IDX_W-1:0] wr_idx;
   } uop_type;

   typedef struct packed {
      logic start;
      logic clr;
      logic sub;
   } mac_ctl_type;

   typedef struct packed {
      logic start;
      logic flip;
   } div_ctl_type;

   // product schedule: minors, determinant, translation sums
   function automatic uop_type uop_of(input logic [STEP_W-1:0] s);
      uop_type u;
      int n;
      int r;
      int c;
      int k;
      int r1;
      int r2;
      int c1;
      int c2;
      u = '0;
      n = 0;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            r1 = (r == 2) ? 0 : r + 1;
            r2 = (r == 0) ? 2 : r - 1;
            c1 = (c == 2) ? 0 : c + 1;
            c2 = (c == 0) ? 2 : c - 1;
            if (s == STEP_W'(n)) begin
               u.x_idx = IDX_W'(c1 * 4 + r1);
               u.y_idx = IDX_W'(c2 * 4 + r2);
               u.clr   = 1'b1;
            end
            n++;
            if (s == STEP_W'(n)) begin
               u.x_idx  = IDX_W'(c1 * 4 + r2);
               u.y_idx  = IDX_W'(c2 * 4 + r1);
               u.sub    = 1'b1;
               u.wr     = 1'b1;
               u.wr_idx = IDX_W'(r * 4 + c);
            end
            n++;
         end
      end
      for (k = 0; k < 3; k++) begin
         if (s == STEP_W'(n)) begin
            u.x_idx  = IDX_W'(k);
            u.y_idx  = IDX_W'(k * 4);
            u.y_num  = 1'b1;
            u.clr    = (k == 0);
            u.wr     = (k == 2);
            u.wr_det = (k == 2);
         end
         n++;
      end
      for (r = 0; r < 3; r++) begin
         for (k = 0; k < 3; k++) begin
            if (s == STEP_W'(n)) begin
               u.x_idx  = IDX_W'(k * 4 + 3);
               u.y_idx  = IDX_W'(r * 4 + k);
               u.y_num  = 1'b1;
               u.clr    = (k == 0);
               u.wr     = (k == 2);
               u.wr_idx = IDX_W'(r * 4 + 3);
            end
            n++;
         end
      end
      return u;
   endfunction

endpackage

/* src/homogeneous_matrix_inverse.sv */
// sequence: after the twelfth item, the cofactor products run on the shared
//    shift-add multiplier, then the divider forms the entries unless singular
// flow: one matrix of twelve items at a time; input stalls while the single
//    multiplier and divider are busy and while the results are emitted
// reset: synchronous active high, clears load count, sequencer and output valid
`timescale 1ns / 1ps

module homogeneous_matrix_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hmi_pkg::DATA_W-1:0]        req_tdata,   // element_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // inverse_value, entry_index, determinant, zero pad
   output logic [hmi_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser,   // singular
   output logic                              rsp_tlast
);
   import hmi_pkg::*;

   `include "homogeneous_matrix_inverse_macros.svh"

   localparam int NUM_W = ACC_W + 2 * FRAC_BITS;

   typedef enum logic [8:0] {
      S_LOAD   = 9'b000000001,
      S_FETCH  = 9'b000000010,
      S_LATCH  = 9'b000000100,
      S_MUL    = 9'b000001000,
      S_CHECK  = 9'b000010000,
      S_SING   = 9'b000100000,
      S_DSTART = 9'b001000000,
      S_DIV    = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        load_ff, load_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [ACC_W-1:0]        num_ff [N_ENTRY];
   logic [ACC_W-1:0]        det_ff;
   logic [DET_W-1:0]        detf_ff, detf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   uop_type                 uop;
   logic                    req_acc;
   logic                    slot_free;
   logic [DATA_W-1:0]       rd_a;
   logic [DATA_W-1:0]       rd_b;
   mac_ctl_type             mac_ctl;
   logic [ACC_W-1:0]        mac_y;
   logic                    mac_busy;
   logic                    mac_done;
   logic [ACC_W-1:0]        mac_acc;
   div_ctl_type             div_ctl;
   logic [NUM_W-1:0]        div_num;
   logic [ACC_W-1:0]        sel_num;
   logic                    div_done;
   logic [DATA_W-1:0]       div_quo;
   logic [ACC_W-1:0]        det_mag;
   logic [ACC_W-1:0]        det_rnd;
   logic                    det_big;
   logic                    det_over;

   assign uop       = uop_of(step_ff);
   assign req_tready = (state_ff == S_LOAD);
   assign req_acc   = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   hmi_ram #(
      .WIDTH (DATA_W),
      .DEPTH (N_ENTRY)
   ) u_matrix_ram (
      .clock   (clock),
      .we      (req_acc),
      .waddr   (load_ff),
      .wdata   (req_tdata),
      .raddr_a (uop.x_idx),
      .raddr_b (uop.y_idx),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   assign mac_ctl.start = (state_ff == S_LATCH);
   assign mac_ctl.clr   = uop.clr;
   assign mac_ctl.sub   = uop.sub;
   assign mac_y = uop.y_num ? num_ff[uop.y_idx] : {{(ACC_W - DATA_W){rd_b[DATA_W-1]}}, rd_b};

   hmi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .x     (rd_a),
      .y     (mac_y),
      .busy  (mac_busy),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   // numerator: scaled adjugate, negated translation sum, fixed bottom row
   always_comb begin
      sel_num       = num_ff[k_ff];
      div_ctl.start = (state_ff == S_DSTART);
      div_ctl.flip  = 1'b0;
      if (k_ff[3:2] == 2'b11) begin
         if (k_ff[1:0] == 2'b11) begin
            div_num = {{(NUM_W - ACC_W){det_ff[ACC_W-1]}}, det_ff} << FRAC_BITS;
         end else begin
            div_num = '0;
         end
      end else if (k_ff[1:0] == 2'b11) begin
         div_num      = {{(NUM_W - ACC_W){sel_num[ACC_W-1]}}, sel_num} << FRAC_BITS;
         div_ctl.flip = 1'b1;
      end else begin
         div_num = {{(NUM_W - ACC_W){sel_num[ACC_W-1]}}, sel_num} << (2 * FRAC_BITS);
      end
   end

   hmi_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // determinant field, rounded half away from zero and saturated
   assign det_mag  = det_ff[ACC_W-1] ? -det_ff : det_ff;
   assign det_rnd  = (det_mag >> FRAC_BITS) + ACC_W'(det_mag[FRAC_BITS-1]);
   assign det_big  = |det_rnd[ACC_W-1:DET_W];
   assign det_over = det_big || (det_ff[ACC_W-1] ? (det_rnd[DET_W-1] && |det_rnd[DET_W-2:0])
                                                 : det_rnd[DET_W-1]);

   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      detf_in      = detf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (load_ff == IDX_W'(N_ENTRY - 1)) begin
                  load_in  = '0;
                  step_in  = '0;
                  state_in = S_FETCH;
               end else begin
                  load_in = load_ff + IDX_W'(1);
               end
            end
         end
         S_FETCH: begin
            state_in = S_LATCH;
         end
         S_LATCH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mac_done) begin
               if (step_ff == STEP_W'(N_UOP - 1)) begin
                  state_in = S_CHECK;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         S_CHECK: begin
            k_in = '0;
            if (det_over) begin
               detf_in = det_ff[ACC_W-1] ? {1'b1, {(DET_W - 1){1'b0}}}
                                         : {1'b0, {(DET_W - 1){1'b1}}};
            end else begin
               detf_in = det_ff[ACC_W-1] ? -det_rnd[DET_W-1:0] : det_rnd[DET_W-1:0];
            end
            state_in = (det_ff == '0) ? S_SING : S_DSTART;
         end
         S_SING: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_LOAD;
            end
         end
         S_DSTART: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - DET_W - IDX_W - DATA_W){1'b0}},
                               detf_ff, k_ff, div_quo};
               rsp_user_in  = 1'b0;
               rsp_last_in  = (k_ff == {IDX_W{1'b1}});
               if (k_ff == {IDX_W{1'b1}}) begin
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_DSTART;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      k_ff        <= k_in;
      detf_ff     <= detf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == S_MUL && mac_done && uop.wr) begin
         if (uop.wr_det) begin
            det_ff <= mac_acc;
         end else begin
            num_ff[uop.wr_idx] <= mac_acc;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;
   assign rsp_tlast    = rsp_last_ff;

   `HMI_ASSERT_IMP(a_sing_clean, rsp_tvalid && rsp_tuser[0], rsp_tlast && rsp_tdata == '0, "singular item not clean")
   `HMI_ASSERT_IMP(a_rsp_source, $rose(rsp_tvalid), $past(state_ff == S_EMIT || state_ff == S_SING), "result from wrong state")
   `HMI_ASSERT_IMP(a_load_range, req_tready, load_ff < IDX_W'(N_ENTRY), "load count out of range")
   `HMI_ASSERT(a_mac_start, !(mac_ctl.start && mac_busy), "multiplier started while busy")

endmodule

/* src/hmi_ram.sv */
`timescale 1ns / 1ps

module hmi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

/* src/hmi_mac.sv */
`timescale 1ns / 1ps

module hmi_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  hmi_pkg::mac_ctl_type          ctl,
   input  logic [hmi_pkg::DATA_W-1:0]    x,
   input  logic [hmi_pkg::ACC_W-1:0]     y,
   output logic                          busy,
   output logic                          done,
   output logic [hmi_pkg::ACC_W-1:0]     acc
);
   import hmi_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] mpl_ff, mpl_in;
   logic [ACC_W-1:0]  mcd_ff, mcd_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              sub_ff, sub_in;
   logic [ACC_W-1:0]  term;
   logic              neg;

   // sign bit of the multiplier carries negative weight
   assign term = mpl_ff[0] ? mcd_ff : '0;
   assign neg  = sub_ff ^ (cnt_ff == CNT_W'(DATA_W - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mpl_in  = mpl_ff;
      mcd_in  = mcd_ff;
      acc_in  = acc_ff;
      sub_in  = sub_ff;
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mpl_in  = x;
         mcd_in  = y;
         sub_in  = ctl.sub;
         acc_in  = ctl.clr ? '0 : acc_ff;
      end else if (busy_ff) begin
         acc_in = neg ? acc_ff - term : acc_ff + term;
         mpl_in = mpl_ff >> 1;
         mcd_in = mcd_ff << 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mpl_ff <= mpl_in;
      mcd_ff <= mcd_in;
      acc_ff <= acc_in;
      sub_ff <= sub_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

/* src/hmi_div.sv */
`timescale 1ns / 1ps

module hmi_div #(
   parameter int NUM_W = 132
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hmi_pkg::div_ctl_type        ctl,
   input  logic [NUM_W-1:0]            num,
   input  logic [hmi_pkg::ACC_W-1:0]   den,
   output logic                        done,
   output logic [hmi_pkg::DATA_W-1:0]  quo
);
   import hmi_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);
   localparam int Q_W   = DATA_W + 1;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_ABS  = 4'b0010,
      D_RUN  = 4'b0100,
      D_FIN  = 4'b1000
   } div_state_type;

   div_state_type     state_ff, state_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ACC_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [ACC_W:0]    rem_ff, rem_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [ACC_W:0]    shifted;
   logic              ge;
   logic [ACC_W+1:0]  twice;
   logic              rnd;
   logic [Q_W:0]      qr;
   logic              over;

   assign shifted = {rem_ff[ACC_W-1:0], num_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign twice   = {rem_ff, 1'b0};
   assign rnd     = twice >= {2'b00, den_ff};
   assign qr      = {1'b0, q_ff} + (Q_W + 1)'(rnd);
   assign over    = ovf_ff || (neg_ff ? (qr > (Q_W + 1)'(34'h0_8000_0000))
                                      : (qr > (Q_W + 1)'(34'h0_7FFF_FFFF)));

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      case (state_ff)
         D_IDLE: begin
            if (ctl.start) begin
               num_in   = num;
               den_in   = den;
               neg_in   = num[NUM_W-1] ^ den[ACC_W-1] ^ ctl.flip;
               state_in = D_ABS;
            end
         end
         D_ABS: begin
            num_in   = num_ff[NUM_W-1] ? -num_ff : num_ff;
            den_in   = den_ff[ACC_W-1] ? -den_ff : den_ff;
            rem_in   = '0;
            q_in     = '0;
            ovf_in   = 1'b0;
            cnt_in   = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
            q_in   = {q_ff[Q_W-2:0], ge};
            ovf_in = ovf_ff | q_ff[Q_W-1];
            num_in = num_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (over) begin
               quo_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               quo_in = neg_ff ? -qr[DATA_W-1:0] : qr[DATA_W-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* sim/homogeneous_matrix_inverse_tb.sv */
`timescale 1ns / 1ps

module homogeneous_matrix_inverse_tb;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] inv_val;
      logic [3:0]  idx;
      logic [63:0] det;
      logic        sing;
      logic        last;
   } inv_entry_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [hmi_pkg::DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [hmi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tlast;

   int error_count = 0;
   int matrix_count = 0;
   int singular_count = 0;
   int saturated_count = 0;
   int idle_cycles = 0;
   bit rand_stall = 1;

   homogeneous_matrix_inverse #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic signed [199:0] div_round(input logic signed [199:0] n,
                                                     input logic signed [199:0] d);
      logic [199:0] nm;
      logic [199:0] dm;
      logic [199:0] q;
      logic [199:0] r;
      nm = n[199] ? -n : n;
      dm = d[199] ? -d : d;
      q = nm / dm;
      r = nm % dm;
      if ((r << 1) >= dm) q = q + 1;
      return (n[199] != d[199]) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [199:0] v);
      if (v > 200'sd2147483647) return 32'h7fffffff;
      if (v < -200'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] clamp64(input logic signed [199:0] v);
      if (v > 200'sd9223372036854775807) return 64'h7fffffffffffffff;
      if (v < -200'sd9223372036854775808) return 64'h8000000000000000;
      return v[63:0];
   endfunction

   class inverse_scoreboard;
      logic [31:0] entries[12];
      int n_loaded = 0;
      inv_entry_type pending[$];

      function void note_element(logic [31:0] v);
         logic signed [199:0] a[3][3];
         logic signed [199:0] t[3];
         logic signed [199:0] adj[3][3];
         logic signed [199:0] det;
         logic signed [199:0] tr;
         logic signed [199:0] num;
         logic [63:0] detf;
         inv_entry_type e;
         int r1, r2, c1, c2;
         entries[n_loaded] = v;
         n_loaded++;
         if (n_loaded < 12) return;
         n_loaded = 0;
         matrix_count++;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) a[r][c] = $signed(entries[r * 4 + c]);
            t[r] = $signed(entries[r * 4 + 3]);
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               c1 = (c + 1) % 3; c2 = (c + 2) % 3;
               r1 = (r + 1) % 3; r2 = (r + 2) % 3;
               adj[r][c] = a[c1][r1] * a[c2][r2] - a[c1][r2] * a[c2][r1];
            end
         end
         det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
         if (det == 0) begin
            singular_count++;
            e = '0;
            e.sing = 1'b1;
            e.last = 1'b1;
            pending.push_back(e);
            return;
         end
         detf = clamp64(div_round(det, 200'sd1 <<< FRAC));
         for (int k = 0; k < 16; k++) begin
            int r;
            int c;
            r = k / 4;
            c = k % 4;
            if (r == 3) num = (c == 3) ? (det <<< FRAC) : 200'sd0;
            else if (c < 3) num = adj[r][c] <<< (2 * FRAC);
            else begin
               tr = adj[r][0] * t[0] + adj[r][1] * t[1] + adj[r][2] * t[2];
               num = (-tr) <<< FRAC;
            end
            e.inv_val = clamp32(div_round(num, det));
            if (e.inv_val == 32'h7fffffff || e.inv_val == 32'h80000000) saturated_count++;
            e.idx = 4'(k);
            e.det = detf;
            e.sing = 1'b0;
            e.last = (k == 15);
            pending.push_back(e);
         end
      endfunction

      task check_result(logic [hmi_pkg::RSP_DATA_W-1:0] data, logic sing, logic last);
         inv_entry_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected item", data[63:0], 64'h0);
            return;
         end
         w = pending.pop_front();
         if (data[31:0] !== w.inv_val) report_mismatch("inverse_value", data[31:0], w.inv_val);
         if (data[35:32] !== w.idx) report_mismatch("entry_index", data[35:32], w.idx);
         if (data[99:36] !== w.det) report_mismatch("determinant", data[99:36], w.det);
         if (sing !== w.sing) report_mismatch("singular", sing, w.sing);
         if (last !== w.last) report_mismatch("last", last, w.last);
      endtask
   endclass

   inverse_scoreboard sb = new();

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   task automatic send_element(input logic [31:0] v);
      int g;
      g = rand_stall ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_element(v);
   endtask

   task automatic send_matrix(input logic [31:0] m[12]);
      for (int i = 0; i < 12; i++) send_element(m[i]);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(($urandom_range(0, 8) - 4)) <<< FRAC;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         3: return 32'($signed($urandom_range(0, 4000)) - 2000);
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 2;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= rand_stall ? ($urandom_range(0, 9) < 7) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0], rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [31:0] m[12];
      int tail;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // identity
      m = '{32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0};
      send_matrix(m);
      // all zero, singular
      m = '{default: 32'h0};
      send_matrix(m);
      // extremes with translation, saturates
      m = '{32'h1, 0, 0, 32'h7fffffff, 0, 32'h1, 0, 32'h80000000, 0, 0, 32'hffffffff, 32'h10000};
      send_matrix(m);
      // rank deficient with nonzero entries
      m = '{32'h10000, 32'h20000, 32'h30000, 32'h5, 32'h20000, 32'h40000, 32'h60000, 32'h7,
            32'hffff0000, 32'h10000, 32'h0, 32'h9};
      send_matrix(m);
      drain();
      rand_stall = 0;
      m = '{32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 0, 32'h80000000, 32'h7fffffff, 0,
            32'h7fffffff, 0, 32'h80000000, 32'haaaaaaaa};
      send_matrix(m);
      rand_stall = 1;
      for (int n = 0; n < 23; n++) begin
         for (int i = 0; i < 12; i++) m[i] = rand_entry();
         if ($urandom_range(0, 5) == 0) for (int i = 0; i < 4; i++) m[4 + i] = m[i];
         if (n == 10) drain();
         if (n == 15) rand_stall = 0;
         if (n == 19) rand_stall = 1;
         send_matrix(m);
      end
      req_tvalid <= 1'b0;
      tail = 0;
      while (sb.pending.size() != 0 && tail < 2000000) begin
         @(posedge clock);
         tail++;
      end
      repeat (3000) @(posedge clock);
      $display("matrices %0d, singular %0d, saturated entries %0d", matrix_count,
               singular_count, saturated_count);
      if (error_count == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* homogeneous_matrix_inverse.f */
+incdir+src
src/hmi_pkg.sv
src/hmi_ram.sv
src/hmi_mac.sv
src/hmi_div.sv
src/homogeneous_matrix_inverse.sv
sim/homogeneous_matrix_inverse_tb.sv
